// ===== rtl/clcd_pkg.sv =====
// Shared types, codes and sequencer step functions for the character LCD interface.
`default_nettype none

package clcd_pkg;

  // Item kinds
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_POWER_UP_WAIT = 3'd0;
  localparam logic [2:0] REG_ENABLE_HIGH   = 3'd1;
  localparam logic [2:0] REG_ENABLE_LOW    = 3'd2;
  localparam logic [2:0] REG_COMMAND_WAIT  = 3'd3;
  localparam logic [2:0] REG_CLEAR_WAIT    = 3'd4;

  // Configuration reset values
  localparam logic [7:0] RST_POWER_UP_WAIT = 8'd20;
  localparam logic [7:0] RST_ENABLE_HIGH   = 8'd1;
  localparam logic [7:0] RST_ENABLE_LOW    = 8'd1;
  localparam logic [7:0] RST_COMMAND_WAIT  = 8'd2;
  localparam logic [7:0] RST_CLEAR_WAIT    = 8'd2;

  // Display commands and init nibbles
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
  localparam logic [3:0] NIB_WAKE         = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT     = 4'h2;
  localparam logic [7:0] INIT_WAIT_FIRST  = 8'd5;
  localparam logic [7:0] INIT_WAIT_NEXT   = 8'd1;

  // Sequencer steps
  localparam logic [4:0] STEP_IDLE        = 5'd0;
  localparam logic [4:0] STEP_POWER_WAIT  = 5'd1;
  localparam logic [4:0] STEP_INIT_HI0    = 5'd2;
  localparam logic [4:0] STEP_INIT_LO0    = 5'd3;
  localparam logic [4:0] STEP_INIT_WAIT0  = 5'd4;
  localparam logic [4:0] STEP_INIT_HI1    = 5'd5;
  localparam logic [4:0] STEP_INIT_LO1    = 5'd6;
  localparam logic [4:0] STEP_INIT_WAIT1  = 5'd7;
  localparam logic [4:0] STEP_INIT_HI2    = 5'd8;
  localparam logic [4:0] STEP_INIT_LO2    = 5'd9;
  localparam logic [4:0] STEP_INIT_WAIT2  = 5'd10;
  localparam logic [4:0] STEP_INIT_HI3    = 5'd11;
  localparam logic [4:0] STEP_INIT_LO3    = 5'd12;
  localparam logic [4:0] STEP_INIT_WAIT3  = 5'd13;
  localparam logic [4:0] STEP_WR_HI       = 5'd14;
  localparam logic [4:0] STEP_WR_HI_GAP   = 5'd15;
  localparam logic [4:0] STEP_WR_LO       = 5'd16;
  localparam logic [4:0] STEP_WR_LO_GAP   = 5'd17;
  localparam logic [4:0] STEP_WR_CMD_WAIT = 5'd18;
  localparam logic [4:0] STEP_WR_CLR_WAIT = 5'd19;
  localparam logic [4:0] STEP_IB_HI       = 5'd20;
  localparam logic [4:0] STEP_IB_HI_GAP   = 5'd21;
  localparam logic [4:0] STEP_IB_LO       = 5'd22;
  localparam logic [4:0] STEP_IB_LO_GAP   = 5'd23;
  localparam logic [4:0] STEP_IB_CMD_WAIT = 5'd24;
  localparam logic [4:0] STEP_IB_CLR_WAIT = 5'd25;

  // Loop bound; longest chain in one item: command wait, clear wait, next byte
  localparam int CHAIN_DEPTH = 4;

  typedef struct packed {
    logic [7:0] power_up_wait;
    logic [7:0] enable_high_ticks;
    logic [7:0] enable_low_ticks;
    logic [7:0] command_wait;
    logic [7:0] clear_wait;
  } clcd_cfg_t;

  typedef struct packed {
    logic [4:0] step;
    logic [7:0] wait_cnt;
    logic [7:0] pbyte;
    logic       psel;
    logic       rs;
    logic       en;
    logic [3:0] data;
  } clcd_state_t;

  function automatic logic [7:0] at_least_one(logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  // Length in ticks of the step held in st.step; zero means skip at once.
  function automatic logic [7:0] step_len(clcd_state_t st, clcd_cfg_t cfg);
    logic [7:0] len;
    len = 8'd0;
    case (st.step)
      STEP_POWER_WAIT: len = cfg.power_up_wait;
      STEP_INIT_HI0, STEP_INIT_HI1, STEP_INIT_HI2, STEP_INIT_HI3,
      STEP_WR_HI, STEP_WR_LO, STEP_IB_HI, STEP_IB_LO:
        len = at_least_one(cfg.enable_high_ticks);
      STEP_INIT_LO0, STEP_INIT_LO1, STEP_INIT_LO2, STEP_INIT_LO3,
      STEP_WR_HI_GAP, STEP_WR_LO_GAP, STEP_IB_HI_GAP, STEP_IB_LO_GAP:
        len = at_least_one(cfg.enable_low_ticks);
      STEP_INIT_WAIT0: len = INIT_WAIT_FIRST;
      STEP_INIT_WAIT1, STEP_INIT_WAIT2, STEP_INIT_WAIT3: len = INIT_WAIT_NEXT;
      STEP_WR_CMD_WAIT, STEP_IB_CMD_WAIT: len = cfg.command_wait;
      STEP_WR_CLR_WAIT, STEP_IB_CLR_WAIT:
        len = (!st.psel && st.pbyte == CMD_CLEAR) ? cfg.clear_wait : 8'd0;
      default: len = 8'd0;
    endcase
    return len;
  endfunction

  // Line levels set on entry to st.step.
  function automatic clcd_state_t apply_entry(clcd_state_t st);
    clcd_state_t r;
    r = st;
    case (st.step)
      STEP_INIT_HI0, STEP_INIT_HI1, STEP_INIT_HI2: begin
        r.data = NIB_WAKE;
        r.en   = 1'b1;
      end
      STEP_INIT_HI3: begin
        r.data = NIB_FOUR_BIT;
        r.en   = 1'b1;
      end
      STEP_WR_HI, STEP_IB_HI: begin
        r.rs   = st.psel;
        r.data = st.pbyte[7:4];
        r.en   = 1'b1;
      end
      STEP_WR_LO, STEP_IB_LO: begin
        r.data = st.pbyte[3:0];
        r.en   = 1'b1;
      end
      STEP_INIT_LO0, STEP_INIT_LO1, STEP_INIT_LO2, STEP_INIT_LO3,
      STEP_WR_HI_GAP, STEP_WR_LO_GAP, STEP_IB_HI_GAP, STEP_IB_LO_GAP:
        r.en = 1'b0;
      default: r = st;
    endcase
    return r;
  endfunction

  // Step that follows st.step; walks the init command list.
  function automatic clcd_state_t advance(clcd_state_t st);
    clcd_state_t r;
    r = st;
    if (st.step == STEP_INIT_WAIT3) begin
      r.pbyte = CMD_FUNCTION_SET;
      r.psel  = 1'b0;
      r.step  = STEP_IB_HI;
    end else if (st.step == STEP_WR_CLR_WAIT) begin
      r.step = STEP_IDLE;
    end else if (st.step == STEP_IB_CLR_WAIT) begin
      case (st.pbyte)
        CMD_FUNCTION_SET: begin
          r.pbyte = CMD_DISPLAY_ON;
          r.step  = STEP_IB_HI;
        end
        CMD_DISPLAY_ON: begin
          r.pbyte = CMD_CLEAR;
          r.step  = STEP_IB_HI;
        end
        CMD_CLEAR: begin
          r.pbyte = CMD_ENTRY_MODE;
          r.step  = STEP_IB_HI;
        end
        default: r.step = STEP_IDLE;
      endcase
    end else if (st.step == STEP_IDLE || st.step > STEP_IB_CLR_WAIT) begin
      r.step = STEP_IDLE;
    end else begin
      r.step = st.step + 5'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/clcd_step.sv =====
// Next-state logic of the LCD timing sequencer for one item.
`default_nettype none

module clcd_step import clcd_pkg::*; (
  input  clcd_state_t state,
  input  clcd_cfg_t   cfg,
  input  logic [1:0]  op,
  input  logic        select_data,
  input  logic [7:0]  value,
  output clcd_state_t state_next,
  output logic        rejected
);

  clcd_state_t st;
  logic        busy;
  logic        enter;
  logic        done;
  logic [7:0]  len;

  assign busy = (state.step != STEP_IDLE);

  always_comb begin
    st       = state;
    rejected = 1'b0;
    enter    = 1'b0;
    done     = 1'b0;
    len      = 8'd0;

    unique case (op)
      OP_TICK: begin
        if (busy) begin
          if (state.wait_cnt > 8'd1) begin
            st.wait_cnt = state.wait_cnt - 8'd1;
          end else begin
            st    = advance(state);
            enter = 1'b1;
          end
        end
      end
      OP_WRITE: begin
        if (busy) begin
          rejected = 1'b1;
        end else begin
          st.psel  = select_data;
          st.pbyte = value;
          st.step  = STEP_WR_HI;
          enter    = 1'b1;
        end
      end
      OP_INIT: begin
        if (busy) begin
          rejected = 1'b1;
        end else begin
          st.rs   = 1'b0;
          st.step = STEP_POWER_WAIT;
          enter   = 1'b1;
        end
      end
      default: ;
    endcase

    // Enter steps until one with a nonzero length, or idle.
    if (enter) begin
      for (int i = 0; i < CHAIN_DEPTH; i++) begin
        if (!done) begin
          if (st.step == STEP_IDLE) begin
            st.wait_cnt = 8'd0;
            done        = 1'b1;
          end else begin
            len = step_len(st, cfg);
            st  = apply_entry(st);
            if (len != 8'd0) begin
              st.wait_cnt = len;
              done        = 1'b1;
            end else begin
              st = advance(st);
            end
          end
        end
      end
    end

    state_next = st;
  end

endmodule

`default_nettype wire

// ===== rtl/char_lcd_nibble_interface_unit.sv =====
// Top level: 4-bit character LCD interface sequencer with stream ports.
// A result appears on m_tvalid in the cycle after its item is accepted.
// Throughput: one item per cycle; s_tready is high while the result register
//   is empty or being drained, so m_tready alone sets the rate.
// Reset (rst, synchronous, active high): sequencer idle, lines low, config
//   registers back to their defaults, result register empty.
`default_nettype none

module char_lcd_nibble_interface_unit import clcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] value
  input  logic [2:0]  s_tuser,   // [1:0] op, [2] select_data
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] rs_line, [1] enable_line, [5:2] data_lines,
                                 // [6] busy_res, [7] rejected
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  clcd_cfg_t   cfg;
  clcd_state_t state;
  clcd_state_t state_next;
  logic        rejected_next;
  logic        accept;

  // Result register frees up when empty or when its item is taken this cycle.
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Register file; indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power_up_wait     <= RST_POWER_UP_WAIT;
      cfg.enable_high_ticks <= RST_ENABLE_HIGH;
      cfg.enable_low_ticks  <= RST_ENABLE_LOW;
      cfg.command_wait      <= RST_COMMAND_WAIT;
      cfg.clear_wait        <= RST_CLEAR_WAIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POWER_UP_WAIT: cfg.power_up_wait     <= cfg_data;
        REG_ENABLE_HIGH:   cfg.enable_high_ticks <= cfg_data;
        REG_ENABLE_LOW:    cfg.enable_low_ticks  <= cfg_data;
        REG_COMMAND_WAIT:  cfg.command_wait      <= cfg_data;
        REG_CLEAR_WAIT:    cfg.clear_wait        <= cfg_data;
        default: ;
      endcase
    end
  end

  // One item's worth of sequencer work: tick countdown, request start,
  // and the chain of zero-length steps it may run through.
  clcd_step u_step (
    .state       (state),
    .cfg         (cfg),
    .op          (s_tuser[1:0]),
    .select_data (s_tuser[2]),
    .value       (s_tdata),
    .state_next  (state_next),
    .rejected    (rejected_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Result register: line levels after the item, busy and reject flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {rejected_next, (state_next.step != STEP_IDLE), state_next.data,
                  state_next.en, state_next.rs};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/clcd_checker.sv =====
// Port-level checks for the LCD interface and their binding to the top level.
`default_nettype none

module clcd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Every accepted item yields a result next cycle.
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted item gave no result");

  // Empty result register never blocks input.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  // A reject only happens while busy, and the block stays busy.
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[7] |-> m_tdata[6])
    else $error("reject reported while idle");

  // Enable is never left high once the sequencer is idle.
  a_enable_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[6])
    else $error("enable high while idle");

endmodule

bind char_lcd_nibble_interface_unit clcd_checker u_clcd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
